// ===== rtl/rgbled_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the RGB LED pulse encoder.
package rgbled_pkg;

   localparam int MAX_LEDS_DEFAULT = 256;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 8;
   localparam int COLOUR_W    = 8;
   localparam int WORD_W      = 3 * COLOUR_W;
   localparam int COUNT_W     = 9;
   localparam int TICK_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [COUNT_W-1:0] LED_COUNT_RESET = 9'd0;
   localparam logic [TICK_W-1:0]  ONE_HIGH_RESET  = 8'd9;
   localparam logic [TICK_W-1:0]  ONE_LOW_RESET   = 8'd3;
   localparam logic [TICK_W-1:0]  ZERO_HIGH_RESET = 8'd3;
   localparam logic [TICK_W-1:0]  ZERO_LOW_RESET  = 8'd9;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_FLUSH = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LED_COUNT = 3'd0,
      CSR_ONE_HIGH  = 3'd1,
      CSR_ONE_LOW   = 3'd2,
      CSR_ZERO_HIGH = 3'd3,
      CSR_ZERO_LOW  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic accepted;
   } rsp_type;

   // a programmed length of zero counts as one tick
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

// ===== rtl/rgbled_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rgbled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read of an address written in the same cycle returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgb_led_pulse_encoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the RGB LED pulse encoder: colour store, frame sequencer, pulse timer.
//
// Pulse encoder for a chain of serial RGB LEDs. Colours live in a RAM of one
// 24-bit word per LED (red, green, blue), MAX_LEDS deep. A write item updates
// one LED and marks the store changed if any byte differs; a flush item starts
// a frame when the LED count is nonzero and something changed, or queues itself
// while a frame runs. Writes during a frame are dropped (accepted = 0) so the
// frame sends a consistent snapshot. Each tick item is one timebase clock: the
// result carries the line level for that tick. Bits go out MSB first in store
// order, each as a high phase then a low phase whose tick counts come from the
// CSRs (zero reads as one). Throughput is one item per clock with no bubbles
// while responses are taken and no clearing pass runs; the RAM read takes the
// accept cycle, followed by the state update and the response register.
// A stalled response holds one item in the execute stage and drops req_ready.
// After reset a clearing pass writes zero to every RAM word, one per clock,
// and req_ready stays low until it ends; CSR writes are taken throughout.
// CSR writes take effect at once, also in the middle of a frame.
module rgb_led_pulse_encoder_unit #(
   parameter int MAX_LEDS = rgbled_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rgbled_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbled_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rgbled_pkg::OP_W-1:0]        req_op,
   input  logic [rgbled_pkg::INDEX_W-1:0]     req_led_index,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_red,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_green,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_line_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_accepted
);
   import rgbled_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;  // RAM address
   localparam int PW = $clog2(MAX_LEDS + 1);                   // LED pointer / count

   // CSRs
   logic [COUNT_W-1:0] led_count_ff;
   logic [TICK_W-1:0]  one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;

   // clearing pass
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // execute stage (item whose RAM word is being read)
   logic                 s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]      s1_op_ff;
   logic [INDEX_W-1:0]   s1_index_ff;
   logic [WORD_W-1:0]    s1_rgb_ff;
   logic                 s1_fire, s1_take;

   // frame state
   logic              sending_ff, sending_in;
   logic              pending_ff, pending_in;
   logic              changed_ff, changed_in;
   logic [PW-1:0]     led_ptr_ff, led_ptr_in;
   logic [1:0]        byte_sel_ff, byte_sel_in;   // 0 red, 1 green, 2 blue
   logic [2:0]        bit_pos_ff, bit_pos_in;
   logic              low_phase_ff, low_phase_in;
   logic [TICK_W-1:0] tick_cnt_ff, tick_cnt_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // RAM and write-to-read forwarding
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic              fwd_hit_ff;
   logic [WORD_W-1:0] fwd_data_ff;

   // datapath helpers
   logic [WORD_W-1:0]   cur_word;
   logic [COLOUR_W-1:0] cur_byte;
   logic                cur_bit;
   logic [TICK_W-1:0]   phase_len, tick_next;
   logic                tick_more;
   logic [PW-1:0]       eff_count, led_ptr_step, led_ptr_next;
   logic                frame_done, idx_ok, can_start;
   logic [INDEX_W-1:0]  next_index;

   // -------------------------------------------------------------------------
   // CSR write port
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= LED_COUNT_RESET;
         one_high_ff  <= ONE_HIGH_RESET;
         one_low_ff   <= ONE_LOW_RESET;
         zero_high_ff <= ZERO_HIGH_RESET;
         zero_low_ff  <= ZERO_LOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LED_COUNT: led_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ONE_HIGH:  one_high_ff  <= csr_wdata[TICK_W-1:0];
            CSR_ONE_LOW:   one_low_ff   <= csr_wdata[TICK_W-1:0];
            CSR_ZERO_HIGH: zero_high_ff <= csr_wdata[TICK_W-1:0];
            CSR_ZERO_LOW:  zero_low_ff  <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // LED count saturated at the store size
   assign eff_count = (32'(led_count_ff) > 32'(MAX_LEDS)) ? PW'(MAX_LEDS)
                                                          : PW'(led_count_ff);

   // -------------------------------------------------------------------------
   // Handshakes
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_active_ff && (!s1_valid_ff || s1_fire);
   assign s1_take   = req_valid && req_ready;

   assign s1_valid_in  = s1_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // -------------------------------------------------------------------------
   // Current LED word: RAM read data, or the word written last cycle at that address
   assign cur_word = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   always_comb begin
      case (byte_sel_ff)
         2'd0:    cur_byte = cur_word[3*COLOUR_W-1:2*COLOUR_W];
         2'd1:    cur_byte = cur_word[2*COLOUR_W-1:COLOUR_W];
         default: cur_byte = cur_word[COLOUR_W-1:0];
      endcase
   end

   assign cur_bit = cur_byte[3'd7 - bit_pos_ff];

   always_comb begin
      if (low_phase_ff) begin
         phase_len = at_least_one(cur_bit ? one_low_ff : zero_low_ff);
      end else begin
         phase_len = at_least_one(cur_bit ? one_high_ff : zero_high_ff);
      end
   end

   assign tick_next = tick_cnt_ff + TICK_W'(1);
   assign tick_more = (tick_next != '0) && (tick_next < phase_len);

   // byte boundary: frame ends once the byte position reaches 3 * count,
   // i.e. once the LED pointer reaches the count
   assign led_ptr_step = led_ptr_ff + PW'(1);
   assign led_ptr_next = (byte_sel_ff == 2'd2) ? led_ptr_step : led_ptr_ff;
   assign frame_done   = (led_ptr_next >= eff_count);

   assign idx_ok    = 32'(s1_index_ff) < 32'(eff_count);
   assign can_start = (eff_count != '0) && changed_ff;

   // -------------------------------------------------------------------------
   // Execute: one item per clock while the response register can take it
   always_comb begin
      sending_in   = sending_ff;
      pending_in   = pending_ff;
      changed_in   = changed_ff;
      led_ptr_in   = led_ptr_ff;
      byte_sel_in  = byte_sel_ff;
      bit_pos_in   = bit_pos_ff;
      low_phase_in = low_phase_ff;
      tick_cnt_in  = tick_cnt_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = AW'(s1_index_ff);
      ram_wdata    = s1_rgb_ff;

      if (clr_active_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (s1_fire) begin
         rsp_in = '0;
         case (s1_op_ff)
            OP_TICK: begin
               if (sending_ff) begin
                  rsp_in.line_level = !low_phase_ff;
                  rsp_in.busy_res   = 1'b1;
                  if (tick_more) begin
                     tick_cnt_in = tick_next;
                  end else begin
                     tick_cnt_in = '0;
                     if (!low_phase_ff) begin
                        low_phase_in = 1'b1;
                     end else begin
                        low_phase_in = 1'b0;
                        if (bit_pos_ff != 3'd7) begin
                           bit_pos_in = bit_pos_ff + 3'd1;
                        end else begin
                           bit_pos_in  = '0;
                           led_ptr_in  = led_ptr_next;
                           byte_sel_in = (byte_sel_ff == 2'd2) ? 2'd0 : byte_sel_ff + 2'd1;
                           if (frame_done) begin
                              sending_in  = 1'b0;
                              led_ptr_in  = '0;
                              byte_sel_in = '0;
                              // queued flush gets a fresh look at frame end
                              if (pending_ff) begin
                                 pending_in = 1'b0;
                                 if (can_start) begin
                                    sending_in = 1'b1;
                                    changed_in = 1'b0;
                                 end
                              end
                           end
                        end
                     end
                  end
               end
            end
            OP_WRITE: begin
               if (!sending_ff && idx_ok) begin
                  ram_we            = 1'b1;
                  changed_in        = changed_ff || (cur_word != s1_rgb_ff);
                  rsp_in.accepted   = 1'b1;
               end
            end
            OP_FLUSH: begin
               if (sending_ff) begin
                  pending_in      = 1'b1;
                  rsp_in.accepted = 1'b1;
               end else if (can_start) begin
                  sending_in      = 1'b1;
                  changed_in      = 1'b0;
                  led_ptr_in      = '0;
                  byte_sel_in     = '0;
                  bit_pos_in      = '0;
                  low_phase_in    = 1'b0;
                  tick_cnt_in     = '0;
                  rsp_in.accepted = 1'b1;
               end
            end
            default: ;
         endcase

         // non-tick items report the line as it stands after the item
         if (s1_op_ff != OP_TICK) begin
            rsp_in.line_level = sending_in && !low_phase_in;
            rsp_in.busy_res   = sending_in;
         end
      end
   end

   // -------------------------------------------------------------------------
   // RAM read address. While a frame runs the RAM streams the word of the LED
   // being sent (no writes then); otherwise it fetches the word of the write
   // item that enters (or stays in) the execute stage.
   assign next_index = s1_take ? req_led_index : s1_index_ff;
   assign ram_raddr  = sending_in ? led_ptr_in[AW-1:0] : AW'(next_index);

   rgbled_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // -------------------------------------------------------------------------
   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sending_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         changed_ff    <= 1'b1;
         led_ptr_ff    <= '0;
         byte_sel_ff   <= '0;
         bit_pos_ff    <= '0;
         low_phase_ff  <= 1'b0;
         tick_cnt_ff   <= '0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_LEDS - 1)) begin
               clr_active_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sending_ff   <= sending_in;
         pending_ff   <= pending_in;
         changed_ff   <= changed_in;
         led_ptr_ff   <= led_ptr_in;
         byte_sel_ff  <= byte_sel_in;
         bit_pos_ff   <= bit_pos_in;
         low_phase_ff <= low_phase_in;
         tick_cnt_ff  <= tick_cnt_in;
         fwd_hit_ff   <= ram_we && (ram_waddr == ram_raddr);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_op_ff    <= req_op;
         s1_index_ff <= req_led_index;
         s1_rgb_ff   <= {req_red, req_green, req_blue};
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
      fwd_data_ff <= ram_wdata;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_ff.line_level;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_accepted   = rsp_ff.accepted;

endmodule

// ===== verif/rgb_led_pulse_encoder_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the RGB LED pulse encoder: predicts every response and compares.
module rgb_led_pulse_encoder_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rgbled_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgbled_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [rgbled_pkg::OP_W-1:0]        req_op,
   input  logic [rgbled_pkg::INDEX_W-1:0]     req_led_index,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_red,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_green,
   input  logic [rgbled_pkg::COLOUR_W-1:0]    req_blue,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_line_level,
   input  logic                               rsp_busy_res,
   input  logic                               rsp_accepted,
   output int                                 fail_count,
   output int                                 expect_count,
   output int                                 checked_count,
   output int                                 frames_started,
   output int                                 frames_ended
);
   import rgbled_pkg::*;

   localparam int STORE_BYTES = 3 * MAX_LEDS_DEFAULT;

   // register copy
   logic [COUNT_W-1:0] led_cnt;
   logic [TICK_W-1:0]  one_hi, one_lo, zero_hi, zero_lo;

   // encoder state
   logic [COLOUR_W-1:0] colour_mem [0:STORE_BYTES-1];
   logic                dirty, sending, flush_queued, low_phase;
   logic [9:0]          byte_pos;
   logic [2:0]          bit_pos;
   logic [TICK_W-1:0]   tick_cnt;

   rsp_type due_rsp_q [$];
   int      fails, checked, started, ended;

   function automatic int eff_leds();
      return (led_cnt > MAX_LEDS_DEFAULT) ? MAX_LEDS_DEFAULT : int'(led_cnt);
   endfunction

   function automatic bit start_frame();
      if (eff_leds() == 0 || !dirty) return 1'b0;
      sending   = 1'b1;
      byte_pos  = '0;
      bit_pos   = '0;
      low_phase = 1'b0;
      tick_cnt  = '0;
      dirty     = 1'b0;
      started++;
      return 1'b1;
   endfunction

   function automatic rsp_type encoder_step(input logic [OP_W-1:0] op,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [WORD_W-1:0] rgb);
      rsp_type             res;
      logic [COLOUR_W-1:0] cur;
      logic [TICK_W-1:0]   len;
      logic                one;
      int                  p;
      res = '0;
      if (op == OP_TICK) begin
         if (sending) begin
            res.line_level = !low_phase;
            res.busy_res   = 1'b1;
            cur = (byte_pos < STORE_BYTES) ? colour_mem[byte_pos] : '0;
            one = cur[3'd7 - bit_pos];
            if (low_phase) len = one ? one_lo : zero_lo;
            else len = one ? one_hi : zero_hi;
            if (len == '0) len = 8'd1;
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt == '0 || tick_cnt >= len) begin
               tick_cnt = '0;
               if (!low_phase) begin
                  low_phase = 1'b1;
               end else begin
                  low_phase = 1'b0;
                  if (bit_pos != 3'd7) begin
                     bit_pos = bit_pos + 3'd1;
                  end else begin
                     bit_pos  = '0;
                     byte_pos = byte_pos + 10'd1;
                     // frame ends at the first byte boundary at or past 3 * count
                     if (byte_pos >= 3 * eff_leds() || byte_pos == '0) begin
                        sending  = 1'b0;
                        byte_pos = '0;
                        ended++;
                        if (flush_queued) begin
                           flush_queued = 1'b0;
                           void'(start_frame());
                        end
                     end
                  end
               end
            end
         end
      end else begin
         if (op == OP_WRITE) begin
            if (!sending && idx < eff_leds()) begin
               for (int k = 0; k < 3; k++) begin
                  p = int'(idx) * 3 + k;
                  if (colour_mem[p] != rgb[23-8*k -: 8]) begin
                     colour_mem[p] = rgb[23-8*k -: 8];
                     dirty = 1'b1;
                  end
               end
               res.accepted = 1'b1;
            end
         end else if (op == OP_FLUSH) begin
            if (sending) begin
               flush_queued = 1'b1;
               res.accepted = 1'b1;
            end else begin
               res.accepted = start_frame();
            end
         end
         res.line_level = sending && !low_phase;
         res.busy_res   = sending;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++) colour_mem[i] = '0;
         dirty        = 1'b1;
         sending      = 1'b0;
         flush_queued = 1'b0;
         low_phase    = 1'b0;
         byte_pos     = '0;
         bit_pos      = '0;
         tick_cnt     = '0;
         led_cnt      = LED_COUNT_RESET;
         one_hi       = ONE_HIGH_RESET;
         one_lo       = ONE_LOW_RESET;
         zero_hi      = ZERO_HIGH_RESET;
         zero_lo      = ZERO_LOW_RESET;
         due_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LED_COUNT: led_cnt = csr_wdata[COUNT_W-1:0];
               CSR_ONE_HIGH:  one_hi  = csr_wdata[TICK_W-1:0];
               CSR_ONE_LOW:   one_lo  = csr_wdata[TICK_W-1:0];
               CSR_ZERO_HIGH: zero_hi = csr_wdata[TICK_W-1:0];
               CSR_ZERO_LOW:  zero_lo = csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_rsp_q.size() == 0) begin
               if (fails < 10)
                  $display("%t: response transfer with nothing outstanding", $realtime);
               fails++;
            end else begin
               want = due_rsp_q.pop_front();
               if (want.line_level !== rsp_line_level || want.busy_res !== rsp_busy_res ||
                   want.accepted !== rsp_accepted) begin
                  if (fails < 10)
                     $display("%t: response %0d mismatch: level/busy/acc %s %b%b%b, got %b%b%b",
                              $realtime, checked, "expected", want.line_level,
                              want.busy_res, want.accepted, rsp_line_level,
                              rsp_busy_res, rsp_accepted);
                  fails++;
               end
               checked++;
            end
         end
         if (req_valid && req_ready)
            due_rsp_q.push_back(encoder_step(req_op, req_led_index,
                                             {req_red, req_green, req_blue}));
      end
      fail_count     <= fails;
      expect_count   <= due_rsp_q.size();
      checked_count  <= checked;
      frames_started <= started;
      frames_ended   <= ended;
   end

endmodule

// ===== verif/tb_rgb_led_pulse_encoder_unit.sv =====
`timescale 1ns / 1ps
// Testbench top of the RGB LED pulse encoder: stimulus, handshake pacing and verdict.
module tb_rgb_led_pulse_encoder_unit;
   import rgbled_pkg::*;

   // op code the block does not define; must change nothing
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_AT_RSP = 150;   // response count that triggers the long hold-off
   localparam int HOLD_CYCLES = 60;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_op         = '0;
   logic [INDEX_W-1:0]     req_led_index  = '0;
   logic [COLOUR_W-1:0]    req_red        = '0;
   logic [COLOUR_W-1:0]    req_green      = '0;
   logic [COLOUR_W-1:0]    req_blue       = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic                   rsp_line_level;
   logic                   rsp_busy_res;
   logic                   rsp_accepted;

   int fail_count, expect_count, checked_count, frames_started, frames_ended;

   // pacing knobs, percent of cycles spent idle on each side
   int send_idle_pct = 16;
   int recv_idle_pct = 69;
   int items_sent    = 0;

   // receiver-side bookkeeping for the one long hold-off
   int rsp_taken = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   // stimulus-side copy of the registers, used to size tick runs and pick LED indices
   logic [COUNT_W-1:0] cfg_count = LED_COUNT_RESET;
   logic [TICK_W-1:0]  cfg_oh    = ONE_HIGH_RESET;
   logic [TICK_W-1:0]  cfg_ol    = ONE_LOW_RESET;
   logic [TICK_W-1:0]  cfg_zh    = ZERO_HIGH_RESET;
   logic [TICK_W-1:0]  cfg_zl    = ZERO_LOW_RESET;

   // last colour offered per LED; reusing it makes writes that change nothing
   bit [WORD_W-1:0] last_rgb [256];

   always #5 clock = ~clock;

   rgb_led_pulse_encoder_unit #(
      .MAX_LEDS(MAX_LEDS_DEFAULT)
   ) u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_led_index(req_led_index), .req_red(req_red), .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_line_level(rsp_line_level),
      .rsp_busy_res(rsp_busy_res), .rsp_accepted(rsp_accepted)
   );

   rgb_led_pulse_encoder_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_led_index(req_led_index), .req_red(req_red), .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_line_level(rsp_line_level),
      .rsp_busy_res(rsp_busy_res), .rsp_accepted(rsp_accepted),
      .fail_count(fail_count), .expect_count(expect_count),
      .checked_count(checked_count), .frames_started(frames_started),
      .frames_ended(frames_ended)
   );

   // Receiver: random back-pressure, plus one long hold-off after HOLD_AT_RSP
   // transfers. The sender keeps offering during the hold, so the execute
   // stage and response register fill and req_ready has to drop.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         if (rsp_valid && rsp_ready) rsp_taken = rsp_taken + 1;
         if (rsp_taken >= HOLD_AT_RSP && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255, 0));
   endfunction

   // zero-length phases run as one tick
   function automatic int tick_len(input logic [TICK_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   // One request transfer. Valid only drops on an idle cycle, so back-to-back
   // items keep it high across the boundary.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic [COLOUR_W-1:0] r, input logic [COLOUR_W-1:0] g,
                            input logic [COLOUR_W-1:0] b);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_led_index <= idx;
      req_red       <= r;
      req_green     <= g;
      req_blue      <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Park the request side and wait until every response is back; the block
   // answers every item, so an empty scoreboard means it is idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expect_count != 0);
   endtask

   task automatic set_csr(input csr_index_type which, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      case (which)
         CSR_LED_COUNT: cfg_count = value[COUNT_W-1:0];
         CSR_ONE_HIGH:  cfg_oh    = value[TICK_W-1:0];
         CSR_ONE_LOW:   cfg_ol    = value[TICK_W-1:0];
         CSR_ZERO_HIGH: cfg_zh    = value[TICK_W-1:0];
         CSR_ZERO_LOW:  cfg_zl    = value[TICK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] count,
                               input logic [CSR_DATA_W-1:0] oh, input logic [CSR_DATA_W-1:0] ol,
                               input logic [CSR_DATA_W-1:0] zh, input logic [CSR_DATA_W-1:0] zl);
      wait_idle();
      set_csr(CSR_LED_COUNT, count);
      set_csr(CSR_ONE_HIGH, oh);
      set_csr(CSR_ONE_LOW, ol);
      set_csr(CSR_ZERO_HIGH, zh);
      set_csr(CSR_ZERO_LOW, zl);
      csr_we <= 1'b0;
   endtask

   // mostly in-range LEDs; a quarter repeat the colour last offered
   task automatic send_random_write();
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  rgb;
      int                 eff;
      eff = (cfg_count > MAX_LEDS_DEFAULT) ? MAX_LEDS_DEFAULT : int'(cfg_count);
      if (eff != 0 && $urandom_range(99, 0) < 90) idx = INDEX_W'($urandom_range(eff - 1, 0));
      else idx = rand_byte();
      if ($urandom_range(99, 0) < 25) rgb = last_rgb[idx];
      else rgb = WORD_W'($urandom);
      last_rgb[idx] = rgb;
      send_item(OP_WRITE, idx, rgb[23:16], rgb[15:8], rgb[7:0]);
   endtask

   // any op including the unused one, all fields random
   task automatic send_noise();
      send_item(OP_W'($urandom_range(3, 0)), rand_byte(), rand_byte(), rand_byte(),
                rand_byte());
   endtask

   // Mostly well-formed frames: a few writes, a flush, then a tick run sized
   // near the expected frame length so frames often (not always) complete,
   // trimmed so the phase stays within its item budget.
   // The rest is short bursts of noise.
   task automatic run_phase(input int budget, input int tick_cap);
      int stop_at, eff, est, run_len;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99, 0) < 80) begin
            repeat ($urandom_range(4, 0)) send_random_write();
            send_item(OP_FLUSH, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            eff = (cfg_count > MAX_LEDS_DEFAULT) ? MAX_LEDS_DEFAULT : int'(cfg_count);
            // 24 bits per LED, each bit one high and one low phase
            est = eff * 12 * (tick_len(cfg_oh) + tick_len(cfg_ol) +
                              tick_len(cfg_zh) + tick_len(cfg_zl));
            run_len = $urandom_range(est + est / 4, est / 2);
            if (run_len > tick_cap) run_len = tick_cap;
            if (run_len > stop_at - items_sent) run_len = stop_at - items_sent;
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(99, 0) < 8) send_noise();
               else send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            end
         end else begin
            repeat ($urandom_range(6, 1)) send_noise();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset registers (count zero): idle tick, unused op,
      // write past the count, flush with nothing to send.
      send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_WRITE, 8'h00, 8'hFF, 8'h00, 8'h80);
      send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00);

      // two LEDs; a zero low length for one bits behaves as one tick
      write_config(9'd2, 9'd1, 9'd0, 9'd2, 9'd1);
      send_item(OP_WRITE, 8'h00, 8'hFF, 8'h00, 8'h80);
      send_item(OP_WRITE, 8'h01, 8'h00, 8'hFF, 8'h01);
      send_item(OP_WRITE, 8'h01, 8'h00, 8'hFF, 8'h01);   // same colour, no change
      send_item(OP_WRITE, 8'h02, 8'h55, 8'hAA, 8'h0F);   // past the count
      send_item(OP_WRITE, 8'hFF, 8'h7F, 8'hFE, 8'hF0);   // top index, past the count
      send_item(OP_FLUSH, 8'hFF, 8'h00, 8'h00, 8'h00);   // starts a frame
      send_item(OP_WRITE, 8'h00, 8'h12, 8'h34, 8'h56);   // dropped while busy
      send_item(OP_FLUSH, 8'h00, 8'hFF, 8'hFF, 8'hFF);   // queued behind the frame
      send_item(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
      repeat (10) send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_byte());

      // lengths and count changed with the frame still running
      wait_idle();
      set_csr(CSR_ZERO_LOW, 9'd3);
      set_csr(CSR_LED_COUNT, 9'd1);
      csr_we <= 1'b0;
      repeat (4) send_item(OP_TICK, rand_byte(), rand_byte(), rand_byte(), rand_byte());

      // random part, stage 1: sender idles a little, receiver a lot
      write_config(9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
      run_phase(100, 200);
      write_config(9'd2, 9'd2, 9'd1, 9'd1, 9'd2);
      run_phase(90, 200);

      // stage 2: the other way round; saturated counts and length extremes
      send_idle_pct = 69;
      recv_idle_pct = 16;
      write_config(9'd256, 9'd0, 9'd0, 9'd0, 9'd0);
      run_phase(60, 50);
      write_config(9'd511, 9'd255, 9'd255, 9'd1, 9'd1);
      run_phase(40, 40);
      // long enough tick runs for a full 255-tick phase
      write_config(9'd1, 9'd255, 9'd0, 9'd0, 9'd255);
      run_phase(300, 300);

      // stage 3: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_config(9'd3, 9'd3, 9'd2, 9'd2, 9'd3);
      run_phase(70, 400);
      write_config(9'd1, 9'd1, 9'd2, 9'd2, 9'd1);
      run_phase(70, 200);

      wait_idle();
      repeat (4) @(posedge clock);   // margin after the scoreboard empties

      $display("covered %0d items and %0d checked responses; %0d frames started, %0d completed",
               items_sent, checked_count, frames_started, frames_ended);
      $display("register setups with zero, small and saturated counts, 0 and 255 tick lengths");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
